/* rtl/core/bcu_pkg.sv */
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the binomial coefficient unit: word width,
// status codes, channel payloads and the request/response bundles of the
// serial divider and multiplier.
// ----------------------------------------------------------------------------
package bcu_pkg;

  localparam int WordW = 32;
  localparam int StepW = $clog2(WordW);
  localparam logic [WordW-1:0] WordMax = '1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StInvalid  = 2'd2
  } bcu_status_e;

  typedef struct packed {
    logic [WordW-1:0] total_n;
    logic [WordW-1:0] chosen_k;
  } bcu_in_t;

  typedef struct packed {
    logic [WordW-1:0] coefficient;
    bcu_status_e      status;
  } bcu_out_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } bcu_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] remainder;
  } bcu_div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] mcand;
    logic [WordW-1:0] mplier;
  } bcu_mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [2*WordW-1:0] product;
  } bcu_mul_rsp_t;

endpackage

/* rtl/core/bcu_stream_if.sv */
// ----------------------------------------------------------------------------
// bcu_stream_if
// Valid/ready channel carrying one payload; a transfer happens on a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bcu_stream_if #(
  parameter type payload_t = logic [0:0]
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/bcu_div.sv */
// ----------------------------------------------------------------------------
// bcu_div
// Restoring radix-2 divider: one quotient bit per cycle until the full
// word is done. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module bcu_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcu_pkg::bcu_div_req_t req_i,
  output bcu_pkg::bcu_div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [bcu_pkg::StepW-1:0]       cnt_q, cnt_d;
  logic [bcu_pkg::WordW-1:0]       rem_q, rem_d;
  logic [bcu_pkg::WordW-1:0]       quo_q, quo_d;
  logic [bcu_pkg::WordW-1:0]       dvs_q, dvs_d;
  logic [bcu_pkg::WordW:0]         trial;
  logic [bcu_pkg::WordW:0]         diff;
  logic                            fits;
  logic                            last;

  assign trial = {rem_q, quo_q[bcu_pkg::WordW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign last  = (cnt_q == bcu_pkg::StepW'(bcu_pkg::WordW - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low word is enough
      rem_d = fits ? diff[bcu_pkg::WordW-1:0] : trial[bcu_pkg::WordW-1:0];
      quo_d = {quo_q[bcu_pkg::WordW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/core/bcu_mul.sv */
// ----------------------------------------------------------------------------
// bcu_mul
// Shift-add multiplier: one multiplier bit per cycle, building the full
// double-width product.
// ----------------------------------------------------------------------------
module bcu_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcu_pkg::bcu_mul_req_t req_i,
  output bcu_pkg::bcu_mul_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [bcu_pkg::StepW-1:0]       cnt_q, cnt_d;
  logic [2*bcu_pkg::WordW-1:0]     prod_q, prod_d;
  logic [bcu_pkg::WordW-1:0]       mcand_q, mcand_d;
  logic [bcu_pkg::WordW:0]         sum;
  logic                            last;

  // add the multiplicand into the high half when the current bit is set
  assign sum  = {1'b0, prod_q[2*bcu_pkg::WordW-1:bcu_pkg::WordW]}
              + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign last = (cnt_q == bcu_pkg::StepW'(bcu_pkg::WordW - 1));

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    mcand_d = mcand_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      prod_d  = {{bcu_pkg::WordW{1'b0}}, req_i.mplier};
      mcand_d = req_i.mcand;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[bcu_pkg::WordW-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = prod_q;

endmodule

/* rtl/core/binomial_coefficient_unit.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient_unit
// Computes n choose k for unsigned 32-bit n and k with the multiplicative
// method, using bit-serial divide and multiply units.
// ----------------------------------------------------------------------------
// One item is worked at a time. S_IDLE takes n and k, S_PREP does the range
// check and symmetry fold (k becomes n - k when that is smaller), then each
// loop step i = 1 .. k runs S_CHECK, a serial division c / i in S_DIV1, a
// pair of serial products (c / i) * m and (c % i) * m in S_MUL, and in S_DIV2
// a second division of the wrapped second product by i. The loop ends when
// i passes the folded k, when the running value reaches zero, or when the
// exact product (c / i) * m no longer fits 32 bits (overflow, coefficient
// 0). Overflow stops the loop within 18 steps. S_DONE loads the result
// register when it is free; the result register lets the next item start
// while the previous result waits to be taken. Status: 0 ok, 1 overflow,
// 2 k greater than n.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  bcu_stream_if.sink       in_i,
  bcu_stream_if.source     out_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int W = bcu_pkg::WordW;

  logic [2:0]            state_q, state_d;
  logic [W-1:0]          n_q, n_d;
  logic [W-1:0]          k_q, k_d;      // folded k after S_PREP
  logic [W-1:0]          c_q, c_d;      // running coefficient
  logic [W-1:0]          m_q, m_d;      // falling factor, n - i + 1
  logic [W-1:0]          i_q, i_d;      // loop index
  logic [W-1:0]          res_coef_q, res_coef_d;
  bcu_pkg::bcu_status_e  res_stat_q, res_stat_d;
  logic                  out_valid_q, out_valid_d;
  bcu_pkg::bcu_out_t     out_data_q, out_data_d;

  logic [W-1:0]          diff_nk;
  logic [W-1:0]          step_sum;

  bcu_pkg::bcu_div_req_t div_req;
  bcu_pkg::bcu_div_rsp_t div_rsp;
  bcu_pkg::bcu_mul_req_t mul0_req, mul1_req;
  bcu_pkg::bcu_mul_rsp_t mul0_rsp, mul1_rsp;

  // shared divider: c / i first, then ((c % i) * m mod 2^32) / i
  bcu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // lane 0: (c / i) * m, full width for the overflow guard
  bcu_mul u_mul0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul0_req),
    .rsp_o  (mul0_rsp)
  );

  // lane 1: (c % i) * m, only the low word is kept
  bcu_mul u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul1_req),
    .rsp_o  (mul1_rsp)
  );

  assign diff_nk  = n_q - k_q;
  // guard passed, so lane 0 fits the word; the sum wraps like the C code
  assign step_sum = mul0_rsp.product[W-1:0] + div_rsp.quotient;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    k_d         = k_q;
    c_d         = c_q;
    m_d         = m_q;
    i_d         = i_q;
    res_coef_d  = res_coef_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    div_req.start     = 1'b0;
    div_req.dividend  = c_q;
    div_req.divisor   = i_q;
    mul0_req.start    = 1'b0;
    mul0_req.mcand    = div_rsp.quotient;
    mul0_req.mplier   = m_q;
    mul1_req.start    = 1'b0;
    mul1_req.mcand    = div_rsp.remainder;
    mul1_req.mplier   = m_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          n_d     = in_i.data.total_n;
          k_d     = in_i.data.chosen_k;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (k_q > n_q) begin
          res_coef_d = '0;
          res_stat_d = bcu_pkg::StInvalid;
          state_d    = S_DONE;
        end else begin
          k_d     = (k_q > diff_nk) ? diff_nk : k_q;
          c_d     = W'(1);
          m_d     = n_q;
          i_d     = W'(1);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((i_q > k_q) || (m_q == '0) || (c_q == '0)) begin
          res_coef_d = c_q;
          res_stat_d = bcu_pkg::StOk;
          state_d    = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          mul0_req.start = 1'b1;
          mul1_req.start = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        if (mul0_rsp.done) begin
          // (c / i) * m above the word is the same test as c / i > max / m
          if (mul0_rsp.product[2*W-1:W] != '0) begin
            res_coef_d = '0;
            res_stat_d = bcu_pkg::StOverflow;
            state_d    = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = mul1_rsp.product[W-1:0];
            state_d          = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          c_d = step_sum;
          m_d = m_q - 1'b1;
          if (i_q == bcu_pkg::WordMax) begin
            res_coef_d = step_sum;
            res_stat_d = bcu_pkg::StOk;
            state_d    = S_DONE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d            = 1'b1;
          out_data_d.coefficient = res_coef_q;
          out_data_d.status      = res_stat_q;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    c_q        <= c_d;
    m_q        <= m_d;
    i_q        <= i_d;
    res_coef_q <= res_coef_d;
    res_stat_q <= res_stat_d;
    out_data_q <= out_data_d;
  end

  // m tracks n - i + 1 throughout the loop
  a_factor_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK || state_q == S_DIV1 || state_q == S_MUL || state_q == S_DIV2)
    |-> ((m_q + i_q) == (n_q + W'(1))))
    else $error("falling factor out of step with loop index");

  // divider is never restarted mid-operation
  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // both multiplier lanes run in lockstep
  a_mul_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul0_rsp.done == mul1_rsp.done) && (mul0_rsp.busy == mul1_rsp.busy))
    else $error("multiplier lanes out of step");

  // failing status always carries a zero coefficient
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.status == bcu_pkg::StOk || out_data_q.coefficient == '0))
    else $error("nonzero coefficient with failing status");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binomial_coefficient_unit. It feeds (n, k) pairs
// over the input channel, predicts n choose k and its status in the bench
// itself, and checks every result transfer against the oldest prediction.
// Both channels idle at random. The sender drains once mid-run.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcu_pkg::*;

  localparam int          NumRandom  = 500;
  localparam int          DrainAfter = 250;   // random items before the drain
  localparam int unsigned StepCap    = 64;    // loop steps allowed per item
  localparam int          IdleLimit  = 40000; // cycles without any transfer
  localparam int          TailCycles = 200;
  localparam int          MaxReports = 10;

  typedef struct packed {
    bcu_in_t          item;
    logic [WordW-1:0] coefficient;
    bcu_status_e      status;
  } choose_expect_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bcu_stream_if #(.payload_t(bcu_in_t))  in_if ();
  bcu_stream_if #(.payload_t(bcu_out_t)) out_if ();

  logic    in_valid_q  = 1'b0;
  bcu_in_t in_data_q   = '0;
  logic    out_ready_q = 1'b0;

  assign in_if.valid  = in_valid_q;
  assign in_if.data   = in_data_q;
  assign out_if.ready = out_ready_q;

  binomial_coefficient_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bcu_in_t        pending_q[$];
  choose_expect_t coef_expect_q[$];

  int issued     = 0;
  int drain_at   = -1;
  int fail_count = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int tx_quiet   = 0;
  int rx_quiet   = 0;
  int idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Multiplicative n choose k with 32-bit wrap; steps reports loop length,
  // StepCap + 1 meaning the loop would run past the cap.
  function automatic void calc_choose(input logic [WordW-1:0] n,
                                      input logic [WordW-1:0] k_in,
                                      output logic [WordW-1:0] coef,
                                      output bcu_status_e st,
                                      output int unsigned steps);
    logic [WordW-1:0] c, m, i, k, q, r, t1, t2;
    c     = 1;
    m     = n;
    k     = k_in;
    steps = 0;
    coef  = '0;
    st    = StOk;
    if (k > n) begin
      st = StInvalid;
      return;
    end
    if (k > n - k) k = n - k;
    i = 1;
    while (i <= k) begin
      if (m == 0 || c == 0) break;
      if (steps == StepCap) begin
        steps = StepCap + 1;
        return;
      end
      q = c / i;
      r = c % i;
      if (q > WordMax / m) begin
        st = StOverflow;
        return;
      end
      t1 = q * m;
      t2 = r * m;
      c  = t1 + t2 / i;
      m  = m - 1;
      steps++;
      if (i == WordMax) break;
      i = i + 1;
    end
    coef = c;
  endfunction

  // Queue a pair only if its loop stays short enough for the run budget.
  function automatic bit push_bounded(input logic [WordW-1:0] n,
                                      input logic [WordW-1:0] k);
    logic [WordW-1:0] c;
    bcu_status_e      st;
    int unsigned      steps;
    calc_choose(n, k, c, st, steps);
    if (steps > StepCap) return 1'b0;
    pending_q.push_back('{total_n: n, chosen_k: k});
    return 1'b1;
  endfunction

  // Random wait per item, with occasional runs of back-to-back items.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Driver: holds an offered item until its transfer, then waits its gap.
  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    logic [WordW-1:0] pc;
    bcu_status_e      pst;
    int unsigned      psteps;
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_data_q  <= '0;
      gap_left    = 0;
    end else begin
      if (in_valid_q && in_if.ready) begin
        calc_choose(in_data_q.total_n, in_data_q.chosen_k, pc, pst, psteps);
        coef_expect_q.push_back('{item: in_data_q, coefficient: pc, status: pst});
        issued++;
        gap_left = draw_wait(tx_quiet);
      end
      if (in_valid_q && !in_if.ready) begin
        // offer stands until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_q <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(issued == drain_at && coef_expect_q.size() != 0)) begin
        in_valid_q <= 1'b1;
        in_data_q  <= pending_q.pop_front();
      end else begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // Monitor: takes results, stalls at random after each, checks each field.
  always @(posedge clk_i or negedge rst_ni) begin : p_check
    choose_expect_t want;
    if (!rst_ni) begin
      out_ready_q <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_if.valid && out_ready_q) begin
        if (coef_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("ERROR: result with nothing pending: coef=%0d status=%0d",
                     out_if.data.coefficient, out_if.data.status);
        end else begin
          want = coef_expect_q.pop_front();
          if (out_if.data.coefficient !== want.coefficient ||
              out_if.data.status !== want.status) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("ERROR: n=%0d k=%0d expected coef=%0d status=%0d, got coef=%0d status=%0d",
                       want.item.total_n, want.item.chosen_k, want.coefficient,
                       want.status, out_if.data.coefficient, out_if.data.status);
          end
        end
        stall_left = draw_wait(rx_quiet);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
      end
    end
  end

  // Watchdog on transfer activity.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_q && in_if.ready) || (out_if.valid && out_ready_q)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("ERROR: no transfer for %0d cycles", IdleLimit);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin : p_stim
    int unsigned      sel;
    logic [WordW-1:0] n, k;
    int               added;

    // Directed: empty sets, k > n, symmetry, word extremes, guard edges.
    void'(push_bounded(0, 0));
    void'(push_bounded(0, 1));
    void'(push_bounded(0, WordMax));
    void'(push_bounded(1, 0));
    void'(push_bounded(1, 1));
    void'(push_bounded(1, 2));
    void'(push_bounded(5, 6));
    void'(push_bounded(7, 3));
    void'(push_bounded(10, 5));
    void'(push_bounded(30, 29));
    void'(push_bounded(33, 16));
    void'(push_bounded(34, 17));
    void'(push_bounded(35, 17));
    void'(push_bounded(67, 33));
    void'(push_bounded(WordMax, 0));
    void'(push_bounded(WordMax, 1));
    void'(push_bounded(WordMax, 2));
    void'(push_bounded(WordMax, WordMax));
    void'(push_bounded(WordMax, WordMax - 1));
    void'(push_bounded(WordMax, 32'h8000_0000));
    void'(push_bounded(32'h8000_0000, 32'h8000_0001));
    void'(push_bounded(32'd65536, 32'd2));
    void'(push_bounded(32'd92682, 32'd2));
    void'(push_bounded(32'd65536, 32'd65535));

    drain_at = pending_q.size() + DrainAfter;

    added = 0;
    while (added < NumRandom) begin
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
        // small sets, some k past n
        n = $urandom_range(0, 40);
        k = $urandom_range(0, n + 2);
      end else if (sel == 5) begin
        n = $urandom_range(0, 70);
        k = $urandom_range(0, n);
      end else if (sel == 6) begin
        n = $urandom;
        k = $urandom_range(0, 4);
      end else if (sel == 7) begin
        n = $urandom;
        k = $urandom;
      end else if (sel == 8) begin
        n = $urandom;
        k = n - $urandom_range(0, 4);
        if (k > n) k = n;
      end else begin
        n = $urandom >> $urandom_range(0, 31);
        k = (n == WordMax) ? $urandom : $urandom % (n + 1);
      end
      if (push_bounded(n, k)) added++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_q) @(posedge clk_i);
    while (coef_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
